>>> hw/rtl/gpp_pkg.sv
// Package for the grid pressure projection block: payload structs, sizes,
// command and register codes, and the sequencer state type.
// No dependencies.
package gpp_pkg;

  localparam int MAX_CELLS_X = 32;
  localparam int MAX_CELLS_Y = 32;
  localparam int CELL_COUNT  = MAX_CELLS_X * MAX_CELLS_Y;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int DIM_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Division by three as multiply by ceil(2^24 / 3) and shift by 24.
  localparam logic [23:0] RECIP3       = 24'd5592406;
  localparam int          RECIP3_SHIFT = 24;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RUN  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELAX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_EN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REST_DENS   = 3'd6;

  localparam logic RES_READ = 1'b0;
  localparam logic RES_RUN  = 1'b1;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] cell_index;
    logic signed [15:0] u_in;
    logic signed [15:0] v_in;
    logic              open_in;
    logic              fluid_in;
    logic [15:0]       density_in;
  } gpp_in_t;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] cell_out;
    logic signed [15:0] u_out;
    logic signed [15:0] v_out;
    logic signed [31:0] pressure_out;
  } gpp_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_OUT,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4,
    ST_DIV,
    ST_MUL1,
    ST_QUO,
    ST_MUL2,
    ST_QUO3,
    ST_MUL3,
    ST_WR1,
    ST_WR2
  } gpp_state_t;

endpackage

>>> hw/rtl/gpp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gpp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/grid_pressure_projection.sv
// Top level of the grid pressure projection block: cell stores, sequencer
// and the shared multiplier. Depends on gpp_pkg and gpp_ram.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------
//   in       | input     | in_valid/in_stall  | in_data (gpp_in_t)
//   out      | output    | out_valid/out_stall| out_data (gpp_out_t)
//   cfg      | input     | cfg_we             | cfg_index, cfg_data
//
// A run request first clears the pressure store, one entry per cycle, then
// visits every interior cell once per sweep. A non-fluid cell or a fluid
// cell with no open neighbor takes fewer steps than an active cell, and one
// with exactly three open neighbors takes more (the divide by three takes a
// second pass through the one shared multiplier). The finish result is
// posted by the last cycle of the last cell, or by the last clearing cycle
// when there is nothing to do. After reset the same clearing pass runs
// before any request is taken. The input is stalled whenever the sequencer
// is busy or a result is still held by a stalled output.
module grid_pressure_projection (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gpp_pkg::gpp_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gpp_pkg::gpp_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [gpp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gpp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import gpp_pkg::*;

  // Configuration registers.
  logic [DIM_W-1:0] cells_x_r;
  logic [DIM_W-1:0] cells_y_r;
  logic [7:0]       sweeps_r;
  logic [14:0]      relax_r;
  logic [23:0]      scale_r;
  logic             drift_r;
  logic [15:0]      rest_r;

  // Sequencer state.
  gpp_state_t        state_r, state_nxt;
  logic              run_r, run_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ADDR_W-1:0] c_r, c_nxt;
  logic [DIM_W-1:0]  x_r, x_nxt;
  logic [DIM_W-1:0]  y_r, y_nxt;
  logic [7:0]        it_r, it_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  gpp_out_t          out_data_r, out_data_nxt;

  // Per-cell operands and intermediate results.
  logic signed [15:0] u_c_r, u_c_nxt;
  logic signed [15:0] v_c_r, v_c_nxt;
  logic signed [15:0] u_rt_r, u_rt_nxt;
  logic signed [15:0] v_tp_r, v_tp_nxt;
  logic [15:0]        dens_r, dens_nxt;
  logic signed [31:0] pr_c_r, pr_c_nxt;
  logic               sl_r, sl_nxt;
  logic               sr_r, sr_nxt;
  logic               sb_r, sb_nxt;
  logic               st_r, st_nxt;
  logic [2:0]         ssum_r, ssum_nxt;
  logic [18:0]        div_mag_r, div_mag_nxt;
  logic               pneg_r, pneg_nxt;
  logic [47:0]        prod_r, prod_nxt;
  logic [20:0]        pmag_r, pmag_nxt;
  logic [20:0]        x3_r, x3_nxt;

  // Memory ports.
  logic              u_we, v_we, f_we, d_we, p_we;
  logic [ADDR_W-1:0] u_waddr, v_waddr, f_waddr, d_waddr, p_waddr;
  logic [15:0]       u_wdata, v_wdata, d_wdata;
  logic [1:0]        f_wdata;
  logic [31:0]       p_wdata;
  logic [ADDR_W-1:0] u_raddr, v_raddr, f_raddr, cd_raddr;
  logic [15:0]       u_rdata, v_rdata, d_rdata;
  logic [1:0]        f_rdata;
  logic [31:0]       p_rdata;

  // Combinational helpers.
  logic [DIM_W-1:0]   nx_eff, ny_eff;
  logic               no_work, last_y, last_x, last_it, advance, in_acc;
  logic [ADDR_W-1:0]  first_c, addr_l, addr_r, addr_b, addr_t;
  logic [2:0]         ssum_w;
  logic signed [19:0] dsum_w, div_w;
  logic signed [17:0] excess_w;
  logic [19:0]        div_neg_w;
  logic [23:0]        mul_a, mul_b;
  logic [34:0]        mag_w;
  logic signed [21:0] p_s;
  logic [43:0]        inc_w;
  logic signed [46:0] pr_ext, inc_ext, pr_sum;
  logic signed [23:0] u_c_new, v_c_new, u_rt_new, v_tp_new;

  function automatic logic signed [15:0] sat16(input logic signed [23:0] val);
    if (val > 24'sd32767) begin
      return 16'sh7fff;
    end else if (val < -24'sd32768) begin
      return 16'sh8000;
    end
    return val[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [46:0] val);
    if (val > 47'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (val < -47'sd2147483648) begin
      return 32'sh80000000;
    end
    return val[31:0];
  endfunction

  // Sizes above the store dimensions are taken as the maxima.
  assign nx_eff  = (cells_x_r > DIM_W'(MAX_CELLS_X)) ? DIM_W'(MAX_CELLS_X) : cells_x_r;
  assign ny_eff  = (cells_y_r > DIM_W'(MAX_CELLS_Y)) ? DIM_W'(MAX_CELLS_Y) : cells_y_r;
  assign no_work = (nx_eff < DIM_W'(3)) || (ny_eff < DIM_W'(3)) || (sweeps_r == 8'd0);

  // The cell address moves by one along y and jumps by three at a column end,
  // which skips the two boundary rows.
  assign first_c = ADDR_W'(ny_eff) + ADDR_W'(1);
  assign addr_l  = c_r - ADDR_W'(ny_eff);
  assign addr_r  = c_r + ADDR_W'(ny_eff);
  assign addr_b  = c_r - ADDR_W'(1);
  assign addr_t  = c_r + ADDR_W'(1);
  assign last_y  = (y_r == ny_eff - DIM_W'(2));
  assign last_x  = (x_r == nx_eff - DIM_W'(2));
  assign last_it = (it_r == sweeps_r - 8'd1);

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Divergence with optional drift compensation. The top open flag arrives
  // straight from the flag memory in the divergence cycle.
  assign ssum_w   = 3'(sl_r) + 3'(sr_r) + 3'(sb_r) + 3'(f_rdata[1]);
  assign dsum_w   = 20'(u_rt_r) - 20'(u_c_r) + 20'(v_tp_r) - 20'(v_c_r);
  assign excess_w = $signed({2'b00, dens_r}) - $signed({2'b00, rest_r});
  assign div_w    = (drift_r && (excess_w > 18'sd0))
                    ? dsum_w - $signed({excess_w[17:0], 2'b00})
                    : dsum_w;
  assign div_neg_w = 20'(-div_w);

  // The shared multiplier takes its operands from the step in progress.
  always_comb begin
    unique case (state_r)
      ST_MUL1: begin
        mul_a = 24'(div_mag_r);
        mul_b = 24'(relax_r);
      end
      ST_MUL2: begin
        mul_a = 24'(x3_r);
        mul_b = RECIP3;
      end
      default: begin
        mul_a = scale_r;
        mul_b = 24'(pmag_r);
      end
    endcase
  end

  // Rounding of the relaxed increment works on magnitudes, so ties round
  // away from zero for both signs.
  assign mag_w    = {1'b0, prod_r[33:0]};
  assign p_s      = pneg_r ? -$signed({1'b0, pmag_r}) : $signed({1'b0, pmag_r});
  assign inc_w    = 44'((prod_r[45:0] + 46'd2) >> 2);
  assign pr_ext   = 47'(pr_c_r);
  assign inc_ext  = $signed({3'b000, inc_w});
  assign pr_sum   = pneg_r ? pr_ext - inc_ext : pr_ext + inc_ext;
  assign u_c_new  = 24'(u_c_r) - (sl_r ? 24'(p_s) : 24'sd0);
  assign v_c_new  = 24'(v_c_r) - (sb_r ? 24'(p_s) : 24'sd0);
  assign u_rt_new = 24'(u_rt_r) + (sr_r ? 24'(p_s) : 24'sd0);
  assign v_tp_new = 24'(v_tp_r) + (st_r ? 24'(p_s) : 24'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= DIM_W'(32);
      cells_y_r <= DIM_W'(32);
      sweeps_r  <= 8'd20;
      relax_r   <= 15'd31130;
      scale_r   <= 24'd256;
      drift_r   <= 1'b1;
      rest_r    <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELLS_X:     cells_x_r <= cfg_data[DIM_W-1:0];
        REG_CELLS_Y:     cells_y_r <= cfg_data[DIM_W-1:0];
        REG_SWEEP_COUNT: sweeps_r  <= cfg_data[7:0];
        REG_RELAX:       relax_r   <= cfg_data[14:0];
        REG_SCALE:       scale_r   <= cfg_data[23:0];
        REG_DRIFT_EN:    drift_r   <= cfg_data[0];
        REG_REST_DENS:   rest_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      run_r       <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r        <= c_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    it_r       <= it_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_data_r <= out_data_nxt;
    u_c_r      <= u_c_nxt;
    v_c_r      <= v_c_nxt;
    u_rt_r     <= u_rt_nxt;
    v_tp_r     <= v_tp_nxt;
    dens_r     <= dens_nxt;
    pr_c_r     <= pr_c_nxt;
    sl_r       <= sl_nxt;
    sr_r       <= sr_nxt;
    sb_r       <= sb_nxt;
    st_r       <= st_nxt;
    ssum_r     <= ssum_nxt;
    div_mag_r  <= div_mag_nxt;
    pneg_r     <= pneg_nxt;
    prod_r     <= prod_nxt;
    pmag_r     <= pmag_nxt;
    x3_r       <= x3_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    clr_nxt       = clr_r;
    c_nxt         = c_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    it_nxt        = it_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    u_c_nxt       = u_c_r;
    v_c_nxt       = v_c_r;
    u_rt_nxt      = u_rt_r;
    v_tp_nxt      = v_tp_r;
    dens_nxt      = dens_r;
    pr_c_nxt      = pr_c_r;
    sl_nxt        = sl_r;
    sr_nxt        = sr_r;
    sb_nxt        = sb_r;
    st_nxt        = st_r;
    ssum_nxt      = ssum_r;
    div_mag_nxt   = div_mag_r;
    pneg_nxt      = pneg_r;
    prod_nxt      = prod_r;
    pmag_nxt      = pmag_r;
    x3_nxt        = x3_r;
    advance       = 1'b0;

    u_we    = 1'b0;
    v_we    = 1'b0;
    f_we    = 1'b0;
    d_we    = 1'b0;
    p_we    = 1'b0;
    u_waddr = c_r;
    v_waddr = c_r;
    f_waddr = in_data.cell_index;
    d_waddr = in_data.cell_index;
    p_waddr = c_r;
    u_wdata = in_data.u_in;
    v_wdata = in_data.v_in;
    f_wdata = {in_data.open_in, in_data.fluid_in};
    d_wdata = in_data.density_in;
    p_wdata = '0;
    u_raddr = c_r;
    v_raddr = c_r;
    f_raddr = c_r;
    cd_raddr = c_r;

    unique case (state_r)
      ST_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_r;
        clr_nxt = clr_r + ADDR_W'(1);
        if (&clr_r) begin
          if (!run_r) begin
            state_nxt = ST_IDLE;
          end else if (no_work) begin
            state_nxt = ST_WR2;
            run_nxt   = 1'b0;
            advance   = 1'b0;
            // An empty run posts its finish result directly.
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_data_nxt.result_kind = RES_RUN;
            state_nxt = ST_IDLE;
          end else begin
            c_nxt     = first_c;
            x_nxt     = DIM_W'(1);
            y_nxt     = DIM_W'(1);
            it_nxt    = 8'd0;
            state_nxt = ST_RD0;
          end
        end
      end
      ST_IDLE: begin
        u_raddr  = in_data.cell_index;
        v_raddr  = in_data.cell_index;
        cd_raddr = in_data.cell_index;
        if (in_acc) begin
          unique case (in_data.command)
            CMD_LOAD: begin
              u_we    = 1'b1;
              v_we    = 1'b1;
              f_we    = 1'b1;
              d_we    = 1'b1;
              u_waddr = in_data.cell_index;
              v_waddr = in_data.cell_index;
            end
            CMD_RUN: begin
              run_nxt   = 1'b1;
              clr_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            CMD_READ: begin
              rd_idx_nxt = in_data.cell_index;
              state_nxt  = ST_READ_OUT;
            end
            default: ;
          endcase
        end
      end
      ST_READ_OUT: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.result_kind  = RES_READ;
        out_data_nxt.cell_out     = rd_idx_r;
        out_data_nxt.u_out        = u_rdata;
        out_data_nxt.v_out        = v_rdata;
        out_data_nxt.pressure_out = p_rdata;
        state_nxt                 = ST_IDLE;
      end
      ST_RD0: begin
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        f_raddr  = addr_l;
        u_raddr  = addr_r;
        v_raddr  = addr_t;
        u_c_nxt  = u_rdata;
        v_c_nxt  = v_rdata;
        dens_nxt = d_rdata;
        pr_c_nxt = p_rdata;
        if (f_rdata[0]) begin
          state_nxt = ST_RD2;
        end else begin
          advance = 1'b1;
        end
      end
      ST_RD2: begin
        f_raddr   = addr_r;
        sl_nxt    = f_rdata[1];
        u_rt_nxt  = u_rdata;
        v_tp_nxt  = v_rdata;
        state_nxt = ST_RD3;
      end
      ST_RD3: begin
        f_raddr   = addr_b;
        sr_nxt    = f_rdata[1];
        state_nxt = ST_RD4;
      end
      ST_RD4: begin
        f_raddr   = addr_t;
        sb_nxt    = f_rdata[1];
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        st_nxt      = f_rdata[1];
        ssum_nxt    = ssum_w;
        pneg_nxt    = div_w > 20'sd0;
        div_mag_nxt = div_w[19] ? div_neg_w[18:0] : div_w[18:0];
        if (ssum_w == 3'd0) begin
          advance = 1'b1;
        end else begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_QUO;
      end
      ST_QUO: begin
        state_nxt = ST_MUL3;
        case (ssum_r)
          3'd1: pmag_nxt = 21'((mag_w + 35'(1 << 13)) >> 14);
          3'd2: pmag_nxt = 21'((mag_w + 35'(1 << 14)) >> 15);
          3'd3: begin
            x3_nxt    = 21'((mag_w + 35'(3 << 13)) >> 14);
            state_nxt = ST_MUL2;
          end
          default: pmag_nxt = 21'((mag_w + 35'(1 << 15)) >> 16);
        endcase
      end
      ST_MUL2: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_QUO3;
      end
      ST_QUO3: begin
        pmag_nxt  = 21'(prod_r >> RECIP3_SHIFT);
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_WR1;
      end
      ST_WR1: begin
        p_we      = 1'b1;
        p_wdata   = sat32(pr_sum);
        u_we      = 1'b1;
        u_wdata   = sat16(u_c_new);
        v_we      = 1'b1;
        v_wdata   = sat16(v_c_new);
        state_nxt = ST_WR2;
      end
      ST_WR2: begin
        u_we    = 1'b1;
        u_waddr = addr_r;
        u_wdata = sat16(u_rt_new);
        v_we    = 1'b1;
        v_waddr = addr_t;
        v_wdata = sat16(v_tp_new);
        advance = 1'b1;
      end
      default: ;
    endcase

    // Step to the next interior cell, the next column or the next sweep, or finish the run.
    if (advance) begin
      state_nxt = ST_RD0;
      if (!last_y) begin
        y_nxt = y_r + DIM_W'(1);
        c_nxt = c_r + ADDR_W'(1);
      end else if (!last_x) begin
        x_nxt = x_r + DIM_W'(1);
        y_nxt = DIM_W'(1);
        c_nxt = c_r + ADDR_W'(3);
      end else if (!last_it) begin
        it_nxt = it_r + 8'd1;
        x_nxt  = DIM_W'(1);
        y_nxt  = DIM_W'(1);
        c_nxt  = first_c;
      end else begin
        run_nxt                  = 1'b0;
        out_valid_nxt            = 1'b1;
        out_data_nxt             = '0;
        out_data_nxt.result_kind = RES_RUN;
        state_nxt                = ST_IDLE;
      end
    end
  end

  gpp_ram #(.WIDTH(16), .DEPTH(CELL_COUNT)) u_store (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  gpp_ram #(.WIDTH(16), .DEPTH(CELL_COUNT)) v_store (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  // Bit 1 holds the open flag, bit 0 the fluid flag.
  gpp_ram #(.WIDTH(2), .DEPTH(CELL_COUNT)) flag_store (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  gpp_ram #(.WIDTH(16), .DEPTH(CELL_COUNT)) density_store (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(cd_raddr), .rdata(d_rdata)
  );

  gpp_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) pressure_store (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(cd_raddr), .rdata(p_rdata)
  );

`ifndef SYNTHESIS
  // A read response is only produced into an empty output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ_OUT) |-> !out_valid_r)
    else $error("read response would overwrite a pending result");

  // Only cells with at least one open neighbor reach the multiplier.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL1) |-> (ssum_r != 3'd0))
    else $error("relaxation started with no open neighbor");

  // The divide-by-three correction always follows its multiply.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QUO3) |-> ($past(state_r) == ST_MUL2))
    else $error("divide-by-three step out of order");

  // A finish result appears only at the end of a run.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r) && out_data_r.result_kind == RES_RUN)
      |-> $past(run_r))
    else $error("finish result without a run");
`endif

endmodule
